### hdl/ffba_pkg.sv
// Types and constants shared by the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  localparam int          HEADER_BYTES = 8;
  localparam logic [31:0] HDR32        = 32'd8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ALIGN   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] request_size;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic [31:0] heap_base;
    logic [31:0] heap_limit;
  } cfg_regs_t;

endpackage
`default_nettype wire

### hdl/ffba_table.sv
// Block table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module ffba_table #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire  [IW-1:0]         waddr,
  input  ffba_pkg::entry_t      wdata,
  input  wire  [IW-1:0]         raddr,
  output ffba_pkg::entry_t      rdata
);
  import ffba_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hdl/ffba_ctrl.sv
// Walk sequencer: streams the table, picks first fit or matching block (or appends one), writes back.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl #(
  parameter int MAX_BLOCKS = 64,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  ffba_pkg::req_t       in_req,
  input  ffba_pkg::cfg_regs_t  cfg,
  output logic                 out_valid,
  output ffba_pkg::rsp_t       out_rsp,
  output logic                 mem_we,
  output logic [IW-1:0]        mem_waddr,
  output ffba_pkg::entry_t     mem_wdata,
  output logic [IW-1:0]        mem_raddr,
  input  ffba_pkg::entry_t     mem_rdata
);
  import ffba_pkg::*;

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t        state_r, state_nxt;
  logic          op_r, op_nxt;
  logic [32:0]   need_r, need_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [CW-1:0] ip_r, ip_nxt;
  logic [IW-1:0] chk_r, chk_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   biu_r, biu_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_rsp_r, out_rsp_nxt;

  logic          hit;
  logic          more;
  logic          append_ok;
  logic [33:0]   end_sum;

  assign more      = ip_r < count_r;
  assign end_sum   = {2'b00, biu_r} + {1'b0, need_r};
  assign append_ok = (count_r < CW'(MAX_BLOCKS)) && (end_sum < {2'b00, cfg.heap_limit});

  always_comb begin
    if (op_r == OP_ALLOC) begin
      hit = rd_vld_r && mem_rdata.free && ({1'b0, mem_rdata.size} >= need_r);
    end else begin
      hit = rd_vld_r && ((cfg.heap_base + off_r + HDR32) == addr_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    need_nxt      = need_r;
    addr_nxt      = addr_r;
    off_nxt       = off_r;
    ip_nxt        = ip_r;
    chk_nxt       = chk_r;
    rd_vld_nxt    = rd_vld_r;
    count_nxt     = count_r;
    biu_nxt       = biu_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_we        = 1'b0;
    mem_waddr     = chk_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = ip_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        mem_raddr = '0;
        if (start) begin
          op_nxt   = in_req.op;
          need_nxt = {1'b0, in_req.request_size} + {1'b0, HDR32};
          addr_nxt = in_req.release_address;
          off_nxt  = '0;
          chk_nxt  = '0;
          if (in_req.op == OP_ALLOC && in_req.request_size[2:0] != 3'd0) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{data_address: 32'd0, status: ST_ALIGN};
          end else begin
            state_nxt = S_WALK;
            // entry 0 is read during the accept cycle
            if (count_r != '0) begin
              ip_nxt     = CW'(1);
              rd_vld_nxt = 1'b1;
            end else begin
              ip_nxt     = '0;
              rd_vld_nxt = 1'b0;
            end
          end
        end
      end
      S_WALK: begin
        if (hit) begin
          mem_we         = 1'b1;
          mem_waddr      = chk_r;
          mem_wdata.size = mem_rdata.size;
          mem_wdata.free = (op_r == OP_FREE);
          out_valid_nxt  = 1'b1;
          out_rsp_nxt.status       = ST_OK;
          out_rsp_nxt.data_address = (op_r == OP_ALLOC) ? cfg.heap_base + off_r + HDR32
                                                        : 32'd0;
          rd_vld_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end else if (!rd_vld_r && !more) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (op_r == OP_FREE) begin
            out_rsp_nxt = '{data_address: 32'd0, status: ST_UNKNOWN};
          end else if (append_ok) begin
            mem_we         = 1'b1;
            mem_waddr      = count_r[IW-1:0];
            mem_wdata.size = need_r[31:0];
            mem_wdata.free = 1'b0;
            count_nxt      = count_r + CW'(1);
            biu_nxt        = biu_r + need_r[31:0];
            out_rsp_nxt.status       = ST_OK;
            out_rsp_nxt.data_address = cfg.heap_base + biu_r + HDR32;
          end else begin
            out_rsp_nxt = '{data_address: 32'd0, status: ST_NOSPACE};
          end
        end else begin
          if (rd_vld_r) begin
            off_nxt = off_r + mem_rdata.size;
          end
          if (more) begin
            ip_nxt     = ip_r + CW'(1);
            chk_nxt    = ip_r[IW-1:0];
            rd_vld_nxt = 1'b1;
          end else begin
            rd_vld_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      ip_r        <= '0;
      count_r     <= '0;
      biu_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      ip_r        <= ip_nxt;
      count_r     <= count_nxt;
      biu_r       <= biu_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    need_r    <= need_nxt;
    addr_r    <= addr_nxt;
    off_r     <= off_nxt;
    chk_r     <= chk_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

### hdl/first_fit_block_allocator_core.sv
// Top level of the first-fit block allocator: config registers, table, sequencer.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  in      | start, busy, in_req                     | request taken on start & !busy
//  out     | out_valid, out_rsp                      | one-cycle strobe, no back-pressure
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | write on cfg_valid & cfg_ready
//
// A misaligned allocate answers in the cycle after the request. Any other request streams
// the block table out of the memory one entry per cycle until a hit or the end of the table;
// the memory read data is registered. A new request is taken in the cycle its predecessor's
// result is shown. Reset empties the table through the block count; the memory itself is
// not cleared.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  ffba_pkg::req_t                      in_req,
  output logic                                out_valid,
  output ffba_pkg::rsp_t                      out_rsp,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [31:0]                         cfg_data
);
  import ffba_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  cfg_regs_t     cfg_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heap_base  <= 32'd0;
      cfg_r.heap_limit <= 32'hffff_ffff;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:  cfg_r.heap_base  <= cfg_data;
        CFG_HEAP_LIMIT: cfg_r.heap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .IW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // misaligned allocate is answered straight from the request
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.op == OP_ALLOC && in_req.request_size[2:0] != 3'd0)
    |=> (out_valid && out_rsp.status == ST_ALIGN))
    else $error("misaligned allocate not flagged");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ST_OK) |-> (out_rsp.data_address == 32'd0))
    else $error("failed request returned a nonzero address");

  // a result is only ever shown while the sequencer is idle
  a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still walking");

  a_walk_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy) && $past(rst_n)) |-> !out_valid)
    else $error("result shown on walk entry");

endmodule
`default_nettype wire
